/* design/keyed_linked_list_engine_macros.svh */
// assertion macros for the keyed linked list engine checker
// expects signals named clock and reset in the including scope
`ifndef KEYED_LINKED_LIST_ENGINE_MACROS_SVH
`define KEYED_LINKED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define KLL_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define KLL_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* design/kll_pkg.sv */
// shared types and constants of the keyed linked list engine
// no dependencies
package kll_pkg;

   localparam int CAPACITY_DEF     = 16;
   localparam int KEY_BITS_DEF     = 16;
   localparam int PAYLOAD_BITS_DEF = 32;

   localparam int OP_BITS     = 3;
   localparam int STATUS_BITS = 2;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_PUSH_FRONT   = 3'd0;
   localparam logic [OP_BITS-1:0] OP_PUSH_BACK    = 3'd1;
   localparam logic [OP_BITS-1:0] OP_POP_FRONT    = 3'd2;
   localparam logic [OP_BITS-1:0] OP_POP_BACK     = 3'd3;
   localparam logic [OP_BITS-1:0] OP_INSERT_AFTER = 3'd4;
   localparam logic [OP_BITS-1:0] OP_REMOVE_KEY   = 3'd5;
   localparam logic [OP_BITS-1:0] OP_LOOKUP       = 3'd6;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_NOMEM = 2'd1,
      ST_EMPTY = 2'd2,
      ST_NOKEY = 2'd3
   } status_type;

   // result handoff from the sequencer to the output stage
   typedef struct packed {
      logic       valid;
      status_type status;
   } res_flags_type;

endpackage

/* design/kll_ram.sv */
// simple dual port ram, one write and one registered read per cycle
// no dependencies
module kll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/kll_ctrl.sv */
// list sequencer: allocation, list walk and link updates over the node rams
// depends on kll_pkg
module kll_ctrl #(
   parameter int CAPACITY     = kll_pkg::CAPACITY_DEF,
   parameter int KEY_BITS     = kll_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = kll_pkg::PAYLOAD_BITS_DEF,
   localparam int IW = $clog2(CAPACITY),
   localparam int LW = $clog2(CAPACITY + 1),
   localparam int DW = KEY_BITS + PAYLOAD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [kll_pkg::OP_BITS-1:0]  req_op,
   input  logic [KEY_BITS-1:0]          req_item_key,
   input  logic [PAYLOAD_BITS-1:0]      req_item_payload,
   input  logic [KEY_BITS-1:0]          req_target_key,
   // result side
   output kll_pkg::res_flags_type       res_flags,
   input  logic                         res_ready,
   output logic [KEY_BITS-1:0]          res_key,
   output logic [PAYLOAD_BITS-1:0]      res_payload,
   output logic [LW-1:0]                res_count,
   // node data ram
   output logic                         data_wr_en,
   output logic [IW-1:0]                data_wr_addr,
   output logic [DW-1:0]                data_wr_data,
   output logic                         data_rd_en,
   output logic [IW-1:0]                data_rd_addr,
   input  logic [DW-1:0]                data_rd_data,
   // node link ram
   output logic                         link_wr_en,
   output logic [IW-1:0]                link_wr_addr,
   output logic [LW-1:0]                link_wr_data,
   output logic                         link_rd_en,
   output logic [IW-1:0]                link_rd_addr,
   input  logic [LW-1:0]                link_rd_data
);

   localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DISPATCH = 5'b00010,
      S_WALK     = 5'b00100,
      S_FIX      = 5'b01000,
      S_RESP     = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      WALK_FIRST = 2'd0,
      WALK_TAIL  = 2'd1,
      WALK_KEY   = 2'd2
   } walk_type;

   state_type state_ff, state_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] fresh_ff, fresh_in;
   logic [LW-1:0] total_ff, total_in;

   walk_type mode_ff, mode_in;
   logic [kll_pkg::OP_BITS-1:0] op_ff, op_in;
   logic [KEY_BITS-1:0] ikey_ff, ikey_in;
   logic [PAYLOAD_BITS-1:0] ipay_ff, ipay_in;
   logic [KEY_BITS-1:0] tkey_ff, tkey_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] prev_ff, prev_in;
   logic [LW-1:0] alloc_next_ff, alloc_next_in;
   logic [IW-1:0] fix_addr_ff, fix_addr_in;
   logic [LW-1:0] fix_val_ff, fix_val_in;
   kll_pkg::status_type res_status_ff, res_status_in;
   logic [KEY_BITS-1:0] res_key_ff, res_key_in;
   logic [PAYLOAD_BITS-1:0] res_pay_ff, res_pay_in;

   logic fresh_avail;
   logic free_avail;
   logic pool_full;
   logic head_empty;
   logic [IW-1:0] new_node;
   logic [KEY_BITS-1:0] rd_key;
   logic [PAYLOAD_BITS-1:0] rd_pay;
   logic hit;

   // never-used nodes are handed out first, then the free chain threaded through links
   assign fresh_avail = (fresh_ff != NULL_LINK);
   assign free_avail  = (free_head_ff != NULL_LINK);
   assign pool_full   = !fresh_avail && !free_avail;
   assign head_empty  = (head_ff == NULL_LINK);
   assign new_node    = fresh_avail ? fresh_ff[IW-1:0] : free_head_ff[IW-1:0];

   assign rd_key = data_rd_data[KEY_BITS-1:0];
   assign rd_pay = data_rd_data[DW-1:KEY_BITS];

   always_comb begin
      unique case (mode_ff)
         WALK_FIRST: hit = 1'b1;
         WALK_TAIL:  hit = (link_rd_data == NULL_LINK);
         WALK_KEY:   hit = (rd_key == tkey_ff);
         default:    hit = 1'b1;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      total_in      = total_ff;
      mode_in       = mode_ff;
      op_in         = op_ff;
      ikey_in       = ikey_ff;
      ipay_in       = ipay_ff;
      tkey_in       = tkey_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      alloc_next_in = alloc_next_ff;
      fix_addr_in   = fix_addr_ff;
      fix_val_in    = fix_val_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;

      data_wr_en   = 1'b0;
      data_wr_addr = new_node;
      data_wr_data = {ipay_ff, ikey_ff};
      data_rd_en   = 1'b0;
      data_rd_addr = head_ff[IW-1:0];
      link_wr_en   = 1'b0;
      link_wr_addr = new_node;
      link_wr_data = NULL_LINK;
      link_rd_en   = 1'b0;
      link_rd_addr = head_ff[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            // prefetch the successor of the free chain head for a possible allocation
            link_rd_en   = free_avail;
            link_rd_addr = free_head_ff[IW-1:0];
            if (req_valid) begin
               op_in    = req_op;
               ikey_in  = req_item_key;
               ipay_in  = req_item_payload;
               tkey_in  = req_target_key;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            res_status_in = kll_pkg::ST_OK;
            res_key_in    = '0;
            res_pay_in    = '0;
            alloc_next_in = link_rd_data;
            cur_in        = head_ff;
            prev_in       = NULL_LINK;
            state_in      = S_RESP;
            unique case (op_ff)
               kll_pkg::OP_PUSH_FRONT, kll_pkg::OP_PUSH_BACK: begin
                  if (pool_full) begin
                     res_status_in = kll_pkg::ST_NOMEM;
                  end else begin
                     data_wr_en   = 1'b1;
                     link_wr_en   = 1'b1;
                     if (op_ff == kll_pkg::OP_PUSH_FRONT || head_empty) begin
                        link_wr_data = head_ff;
                        head_in      = LW'(new_node);
                        if (fresh_avail) begin
                           fresh_in = fresh_ff + 1'b1;
                        end else begin
                           free_head_in = link_rd_data;
                        end
                        total_in = total_ff + 1'b1;
                     end else begin
                        // new tail gets a null link now, the old tail is patched later
                        link_wr_data = NULL_LINK;
                        data_rd_en   = 1'b1;
                        link_rd_en   = 1'b1;
                        mode_in      = WALK_TAIL;
                        state_in     = S_WALK;
                     end
                  end
               end
               kll_pkg::OP_POP_FRONT, kll_pkg::OP_POP_BACK: begin
                  if (head_empty) begin
                     res_status_in = kll_pkg::ST_EMPTY;
                  end else begin
                     data_rd_en = 1'b1;
                     link_rd_en = 1'b1;
                     mode_in    = (op_ff == kll_pkg::OP_POP_FRONT) ? WALK_FIRST : WALK_TAIL;
                     state_in   = S_WALK;
                  end
               end
               kll_pkg::OP_INSERT_AFTER, kll_pkg::OP_REMOVE_KEY, kll_pkg::OP_LOOKUP: begin
                  if (head_empty) begin
                     res_status_in = kll_pkg::ST_NOKEY;
                  end else begin
                     // the candidate node is free, so writing its data early is harmless
                     data_wr_en = (op_ff == kll_pkg::OP_INSERT_AFTER) && !pool_full;
                     data_rd_en = 1'b1;
                     link_rd_en = 1'b1;
                     mode_in    = WALK_KEY;
                     state_in   = S_WALK;
                  end
               end
               default: begin
               end
            endcase
         end

         S_WALK: begin
            data_rd_addr = link_rd_data[IW-1:0];
            link_rd_addr = link_rd_data[IW-1:0];
            if (hit) begin
               state_in = S_RESP;
               unique case (op_ff)
                  kll_pkg::OP_PUSH_BACK: begin
                     link_wr_en   = 1'b1;
                     link_wr_addr = cur_ff[IW-1:0];
                     link_wr_data = LW'(new_node);
                     if (fresh_avail) begin
                        fresh_in = fresh_ff + 1'b1;
                     end else begin
                        free_head_in = alloc_next_ff;
                     end
                     total_in = total_ff + 1'b1;
                  end
                  kll_pkg::OP_POP_FRONT, kll_pkg::OP_POP_BACK, kll_pkg::OP_REMOVE_KEY: begin
                     res_key_in   = rd_key;
                     res_pay_in   = rd_pay;
                     // unlinked node goes on top of the free chain
                     link_wr_en   = 1'b1;
                     link_wr_addr = cur_ff[IW-1:0];
                     link_wr_data = free_head_ff;
                     free_head_in = cur_ff;
                     if (total_ff != '0) begin
                        total_in = total_ff - 1'b1;
                     end
                     if (prev_ff == NULL_LINK) begin
                        head_in = link_rd_data;
                     end else begin
                        fix_addr_in = prev_ff[IW-1:0];
                        fix_val_in  = link_rd_data;
                        state_in    = S_FIX;
                     end
                  end
                  kll_pkg::OP_INSERT_AFTER: begin
                     if (pool_full) begin
                        res_status_in = kll_pkg::ST_NOMEM;
                     end else begin
                        link_wr_en   = 1'b1;
                        link_wr_addr = cur_ff[IW-1:0];
                        link_wr_data = LW'(new_node);
                        fix_addr_in  = new_node;
                        fix_val_in   = link_rd_data;
                        if (fresh_avail) begin
                           fresh_in = fresh_ff + 1'b1;
                        end else begin
                           free_head_in = alloc_next_ff;
                        end
                        total_in = total_ff + 1'b1;
                        state_in = S_FIX;
                     end
                  end
                  kll_pkg::OP_LOOKUP: begin
                     res_key_in = rd_key;
                     res_pay_in = rd_pay;
                  end
                  default: begin
                  end
               endcase
            end else if (mode_ff == WALK_KEY && link_rd_data == NULL_LINK) begin
               res_status_in = kll_pkg::ST_NOKEY;
               state_in      = S_RESP;
            end else begin
               // step to the successor, its read goes out this cycle
               data_rd_en = 1'b1;
               link_rd_en = 1'b1;
               prev_in    = cur_ff;
               cur_in     = link_rd_data;
            end
         end

         S_FIX: begin
            link_wr_en   = 1'b1;
            link_wr_addr = fix_addr_ff;
            link_wr_data = fix_val_ff;
            state_in     = S_RESP;
         end

         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_LINK;
         free_head_ff <= NULL_LINK;
         fresh_ff     <= '0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      op_ff         <= op_in;
      ikey_ff       <= ikey_in;
      ipay_ff       <= ipay_in;
      tkey_ff       <= tkey_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      alloc_next_ff <= alloc_next_in;
      fix_addr_ff   <= fix_addr_in;
      fix_val_ff    <= fix_val_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign res_flags.valid  = (state_ff == S_RESP);
   assign res_flags.status = res_status_ff;
   assign res_key          = res_key_ff;
   assign res_payload      = res_pay_ff;
   assign res_count        = total_ff;

endmodule

/* design/keyed_linked_list_engine.sv */
// keyed linked list engine top: sequencer, node data and link rams, response register
// the list walk visits one node per cycle over the link ram; a new request is taken only
//   once the sequencer is idle again, after the previous result went to the response register
// reset: synchronous active high; list empty, all nodes free, response channel empty
// depends on kll_pkg, kll_ctrl and kll_ram
module keyed_linked_list_engine #(
   parameter int CAPACITY     = kll_pkg::CAPACITY_DEF,
   parameter int KEY_BITS     = kll_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = kll_pkg::PAYLOAD_BITS_DEF,
   localparam int LW       = $clog2(CAPACITY + 1),
   localparam int REQ_BITS = kll_pkg::OP_BITS + 2 * KEY_BITS + PAYLOAD_BITS,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = kll_pkg::STATUS_BITS + KEY_BITS + PAYLOAD_BITS + LW,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // op, item_key, item_payload, target_key (lowest bit up), zero padded
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status, out_key, out_payload, node_count (lowest bit up), zero padded
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int IW = $clog2(CAPACITY);
   localparam int DW = KEY_BITS + PAYLOAD_BITS;

   // request field offsets
   localparam int IKEY_LO = kll_pkg::OP_BITS;
   localparam int IPAY_LO = IKEY_LO + KEY_BITS;
   localparam int TKEY_LO = IPAY_LO + PAYLOAD_BITS;

   kll_pkg::res_flags_type res_flags;
   logic res_ready;
   logic [KEY_BITS-1:0] res_key;
   logic [PAYLOAD_BITS-1:0] res_payload;
   logic [LW-1:0] res_count;

   logic data_wr_en, data_rd_en, link_wr_en, link_rd_en;
   logic [IW-1:0] data_wr_addr, data_rd_addr, link_wr_addr, link_rd_addr;
   logic [DW-1:0] data_wr_data, data_rd_data;
   logic [LW-1:0] link_wr_data, link_rd_data;

   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_load;

   // sequencer owns the list state: head, free chain, fresh count and node total
   kll_ctrl #(
      .CAPACITY     (CAPACITY),
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_kll_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_op           (req_tdata[kll_pkg::OP_BITS-1:0]),
      .req_item_key     (req_tdata[IKEY_LO +: KEY_BITS]),
      .req_item_payload (req_tdata[IPAY_LO +: PAYLOAD_BITS]),
      .req_target_key   (req_tdata[TKEY_LO +: KEY_BITS]),
      .res_flags        (res_flags),
      .res_ready        (res_ready),
      .res_key          (res_key),
      .res_payload      (res_payload),
      .res_count        (res_count),
      .data_wr_en       (data_wr_en),
      .data_wr_addr     (data_wr_addr),
      .data_wr_data     (data_wr_data),
      .data_rd_en       (data_rd_en),
      .data_rd_addr     (data_rd_addr),
      .data_rd_data     (data_rd_data),
      .link_wr_en       (link_wr_en),
      .link_wr_addr     (link_wr_addr),
      .link_wr_data     (link_wr_data),
      .link_rd_en       (link_rd_en),
      .link_rd_addr     (link_rd_addr),
      .link_rd_data     (link_rd_data)
   );

   // key and payload of every node, key in the low bits
   kll_ram #(
      .WIDTH (DW),
      .DEPTH (CAPACITY)
   ) u_kll_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (data_wr_addr),
      .wr_data (data_wr_data),
      .rd_en   (data_rd_en),
      .rd_addr (data_rd_addr),
      .rd_data (data_rd_data)
   );

   // next link of every node, CAPACITY marks the end; free nodes chain through it too
   kll_ram #(
      .WIDTH (LW),
      .DEPTH (CAPACITY)
   ) u_kll_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   // response register: takes a new result when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;
   assign rsp_load  = res_flags.valid && res_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({res_count, res_payload, res_key, res_flags.status});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* design/kll_checker.sv */
// port level checks of the keyed linked list engine and their bind
// depends on kll_pkg and keyed_linked_list_engine_macros.svh
`include "keyed_linked_list_engine_macros.svh"

module kll_checker #(
   parameter int CAPACITY     = kll_pkg::CAPACITY_DEF,
   parameter int KEY_BITS     = kll_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = kll_pkg::PAYLOAD_BITS_DEF,
   localparam int LW       = $clog2(CAPACITY + 1),
   localparam int REQ_BITS = kll_pkg::OP_BITS + 2 * KEY_BITS + PAYLOAD_BITS,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = kll_pkg::STATUS_BITS + KEY_BITS + PAYLOAD_BITS + LW,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   localparam int KEY_LO = kll_pkg::STATUS_BITS;
   localparam int PAY_LO = KEY_LO + KEY_BITS;
   localparam int CNT_LO = PAY_LO + PAYLOAD_BITS;

   logic [kll_pkg::STATUS_BITS-1:0] status;
   logic [KEY_BITS-1:0] out_key;
   logic [PAYLOAD_BITS-1:0] out_payload;
   logic [LW-1:0] node_count;
   logic req_fire;

   assign status      = rsp_tdata[kll_pkg::STATUS_BITS-1:0];
   assign out_key     = rsp_tdata[KEY_LO +: KEY_BITS];
   assign out_payload = rsp_tdata[PAY_LO +: PAYLOAD_BITS];
   assign node_count  = rsp_tdata[CNT_LO +: LW];
   assign req_fire    = req_tvalid && req_tready && (req_tdata[0] || !req_tdata[0]);

   // stalled response holds
   `KLL_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // one request in flight: an accepted request blocks the next cycle
   `KLL_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_tready, "request taken while busy")

   `KLL_ASSERT_NOW(a_count_bound, rsp_tvalid, node_count <= LW'(CAPACITY), "node count beyond capacity")

   `KLL_ASSERT_NOW(a_empty_result, rsp_tvalid && status == kll_pkg::ST_EMPTY, node_count == '0 && out_key == '0 && out_payload == '0, "empty status with items")

   `KLL_ASSERT_NOW(a_nomem_full, rsp_tvalid && status == kll_pkg::ST_NOMEM, node_count == LW'(CAPACITY), "out of memory below capacity")

endmodule

bind keyed_linked_list_engine kll_checker #(
   .CAPACITY     (CAPACITY),
   .KEY_BITS     (KEY_BITS),
   .PAYLOAD_BITS (PAYLOAD_BITS)
) u_kll_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/tb_top.sv */
// self-checking testbench for the keyed linked list engine: directed list corner cases,
// then random list traffic under several idle and stall mixes, plus one long output stall
// depends on kll_pkg and keyed_linked_list_engine
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY       = kll_pkg::CAPACITY_DEF;
   localparam int KEY_W          = kll_pkg::KEY_BITS_DEF;
   localparam int PAY_W          = kll_pkg::PAYLOAD_BITS_DEF;
   localparam int OP_W           = kll_pkg::OP_BITS;
   localparam int REQ_W          = ((OP_W + 2 * KEY_W + PAY_W + 7) / 8) * 8;
   localparam int CNT_W          = $clog2(CAPACITY + 1);
   localparam int RSP_W          = ((kll_pkg::STATUS_BITS + KEY_W + PAY_W + CNT_W + 7)
                                    / 8) * 8;
   localparam int DRAIN_CYCLES   = CAPACITY + 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 150;
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   typedef struct {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } list_entry_type;

   typedef struct packed {
      kll_pkg::status_type status;
      logic [KEY_W-1:0]    out_key;
      logic [PAY_W-1:0]    out_payload;
      logic [CNT_W-1:0]    node_count;
   } list_result_type;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // list contents in order from the head, and results still owed by the block
   list_entry_type  list_contents[$];
   list_result_type owed_results[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_left          = 0;
   int error_count        = 0;
   int requests_sent      = 0;
   int results_checked    = 0;
   int peak_nodes         = 0;
   int quiet_cycles       = 0;
   int status_tally[4]    = '{default: 0};

   keyed_linked_list_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // applies one request to the list copy and returns the result the block owes for it
   function automatic list_result_type apply_list_op(input logic [OP_W-1:0] op,
                                                     input logic [KEY_W-1:0] item_key,
                                                     input logic [PAY_W-1:0] item_payload,
                                                     input logic [KEY_W-1:0] target_key);
      list_result_type res;
      list_entry_type  fresh;
      list_entry_type  gone;
      int              hit;
      res         = '0;
      res.status  = kll_pkg::ST_OK;
      fresh.key     = item_key;
      fresh.payload = item_payload;
      hit = -1;
      // keyed operations act on the first node from the head holding the key
      for (int i = 0; i < list_contents.size(); i++) begin
         if (list_contents[i].key == target_key) begin
            hit = i;
            break;
         end
      end
      case (op)
         kll_pkg::OP_PUSH_FRONT, kll_pkg::OP_PUSH_BACK: begin
            if (list_contents.size() >= CAPACITY) begin
               res.status = kll_pkg::ST_NOMEM;
            end else if (op == kll_pkg::OP_PUSH_FRONT) begin
               list_contents.push_front(fresh);
            end else begin
               list_contents.push_back(fresh);
            end
         end
         kll_pkg::OP_POP_FRONT, kll_pkg::OP_POP_BACK: begin
            if (list_contents.size() == 0) begin
               res.status = kll_pkg::ST_EMPTY;
            end else begin
               gone = (op == kll_pkg::OP_POP_FRONT) ? list_contents.pop_front()
                                                    : list_contents.pop_back();
               res.out_key     = gone.key;
               res.out_payload = gone.payload;
            end
         end
         kll_pkg::OP_REMOVE_KEY: begin
            if (hit < 0) begin
               res.status = kll_pkg::ST_NOKEY;
            end else begin
               res.out_key     = list_contents[hit].key;
               res.out_payload = list_contents[hit].payload;
               list_contents.delete(hit);
            end
         end
         kll_pkg::OP_INSERT_AFTER: begin
            // the search comes before the allocation
            if (hit < 0) begin
               res.status = kll_pkg::ST_NOKEY;
            end else if (list_contents.size() >= CAPACITY) begin
               res.status = kll_pkg::ST_NOMEM;
            end else begin
               list_contents.insert(hit + 1, fresh);
            end
         end
         kll_pkg::OP_LOOKUP: begin
            if (hit < 0) begin
               res.status = kll_pkg::ST_NOKEY;
            end else begin
               res.out_key     = list_contents[hit].key;
               res.out_payload = list_contents[hit].payload;
            end
         end
         default: begin
            // unused code leaves the list alone
         end
      endcase
      res.node_count = CNT_W'(list_contents.size());
      if (list_contents.size() > peak_nodes) peak_nodes = list_contents.size();
      status_tally[res.status]++;
      return res;
   endfunction

   // keys drawn mostly from a small set so that searches hit, with extremes and full range
   function automatic logic [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return KEY_W'($urandom_range(7));
      if (roll < 75) return '1;
      if (roll < 80) return '0;
      return KEY_W'($urandom_range(65535));
   endfunction

   // request and result monitor: predicts on each accepted request, checks each result
   always @(posedge clock) begin : result_check
      list_result_type got;
      list_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status      = kll_pkg::status_type'(rsp_tdata[1:0]);
            got.out_key     = rsp_tdata[17:2];
            got.out_payload = rsp_tdata[49:18];
            got.node_count  = rsp_tdata[54:50];
            if (owed_results.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               want = owed_results.pop_front();
               results_checked++;
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
               if (got.out_key !== want.out_key) begin
                  $error("out_key: expected %h, got %h", want.out_key, got.out_key);
                  error_count++;
               end
               if (got.out_payload !== want.out_payload) begin
                  $error("out_payload: expected %h, got %h", want.out_payload, got.out_payload);
                  error_count++;
               end
               if (got.node_count !== want.node_count) begin
                  $error("node_count: expected %0d, got %0d", want.node_count, got.node_count);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            owed_results.push_back(apply_list_op(req_tdata[2:0], req_tdata[18:3],
                                                 req_tdata[50:19], req_tdata[66:51]));
         end
      end
   end

   // output side: random stalls, or a long counted hold when one is pending
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offers one request and returns at the edge where it is taken; valid is left high
   // so that back to back requests never drop it
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic [KEY_W-1:0] item_key,
                               input logic [PAY_W-1:0] item_payload,
                               input logic [KEY_W-1:0] target_key);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({target_key, item_payload, item_key, op});
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   task automatic test_empty_list();
      send_request(kll_pkg::OP_POP_FRONT, 16'h0001, 32'h1, 16'h0000);
      send_request(kll_pkg::OP_POP_BACK, 16'hffff, 32'hffff_ffff, 16'hffff);
      send_request(kll_pkg::OP_REMOVE_KEY, 16'h0000, 32'h0, 16'h0000);
      send_request(kll_pkg::OP_LOOKUP, 16'h0000, 32'h0, 16'hffff);
      send_request(kll_pkg::OP_INSERT_AFTER, 16'h0005, 32'h5, 16'h0000);
      send_request(OP_UNUSED, 16'hffff, 32'hffff_ffff, 16'hffff);
   endtask

   task automatic test_fill_to_capacity();
      send_request(kll_pkg::OP_PUSH_FRONT, 16'hffff, 32'hffff_ffff, 16'h0000);
      send_request(kll_pkg::OP_PUSH_BACK, 16'h0000, 32'h0000_0000, 16'hffff);
      send_request(kll_pkg::OP_PUSH_BACK, 16'h0001, 32'h5555_5555, 16'h0000);
      // duplicate key at the front, later searches must stop here
      send_request(kll_pkg::OP_PUSH_FRONT, 16'h0001, 32'haaaa_aaaa, 16'h0000);
      send_request(kll_pkg::OP_INSERT_AFTER, 16'h0002, 32'h1234_5678, 16'h0001);
      for (int i = 0; i < CAPACITY - 5; i++) begin
         send_request((i % 2) ? kll_pkg::OP_PUSH_FRONT : kll_pkg::OP_PUSH_BACK,
                      KEY_W'(16'h0100 + i), $urandom, 16'h0000);
      end
   endtask

   task automatic test_full_pool();
      send_request(kll_pkg::OP_PUSH_FRONT, 16'h0bad, 32'hdead_0001, 16'h0000);
      send_request(kll_pkg::OP_PUSH_BACK, 16'h0bad, 32'hdead_0002, 16'h0000);
      send_request(kll_pkg::OP_INSERT_AFTER, 16'h0bad, 32'hdead_0003, 16'h0000);
      // missing target wins over the full pool
      send_request(kll_pkg::OP_INSERT_AFTER, 16'h0bad, 32'hdead_0004, 16'h1234);
   endtask

   task automatic test_keyed_access();
      send_request(kll_pkg::OP_LOOKUP, 16'h0000, 32'h0, 16'h0001);
      send_request(kll_pkg::OP_REMOVE_KEY, 16'h0000, 32'h0, 16'h0001);
      send_request(kll_pkg::OP_LOOKUP, 16'h0000, 32'h0, 16'h0001);
      send_request(kll_pkg::OP_POP_FRONT, 16'h0000, 32'h0, 16'h0000);
      send_request(kll_pkg::OP_POP_BACK, 16'h0000, 32'h0, 16'h0000);
      send_request(kll_pkg::OP_REMOVE_KEY, 16'h0000, 32'h0, 16'hffff);
   endtask

   // random traffic that swings between phases that favour growing the list and phases that favour draining it
   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      logic [OP_W-1:0]  op;
      logic [PAY_W-1:0] payload;
      int               roll;
      bit               growing;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         growing = ((i / 32) % 2) == 0;
         roll = $urandom_range(99);
         if (growing) begin
            op = (roll < 30) ? kll_pkg::OP_PUSH_FRONT   :
                 (roll < 55) ? kll_pkg::OP_PUSH_BACK    :
                 (roll < 70) ? kll_pkg::OP_INSERT_AFTER :
                 (roll < 78) ? kll_pkg::OP_POP_FRONT    :
                 (roll < 84) ? kll_pkg::OP_POP_BACK     :
                 (roll < 92) ? kll_pkg::OP_REMOVE_KEY   :
                 (roll < 98) ? kll_pkg::OP_LOOKUP       : OP_UNUSED;
         end else begin
            op = (roll < 10) ? kll_pkg::OP_PUSH_FRONT   :
                 (roll < 18) ? kll_pkg::OP_PUSH_BACK    :
                 (roll < 25) ? kll_pkg::OP_INSERT_AFTER :
                 (roll < 45) ? kll_pkg::OP_POP_FRONT    :
                 (roll < 65) ? kll_pkg::OP_POP_BACK     :
                 (roll < 85) ? kll_pkg::OP_REMOVE_KEY   :
                 (roll < 97) ? kll_pkg::OP_LOOKUP       : OP_UNUSED;
         end
         roll = $urandom_range(99);
         payload = (roll < 5) ? '0 : (roll < 10) ? '1 : PAY_W'($urandom);
         send_request(op, pick_key(), payload, pick_key());
      end
   endtask

   // output held off for a long stretch while requests keep coming, so the input backs up
   task automatic test_backpressure();
      logic [OP_W-1:0] op;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_left          = LONG_HOLD;
      for (int i = 0; i < 24; i++) begin
         op = (i % 3 == 2) ? kll_pkg::OP_LOOKUP    :
              (i % 3 == 1) ? kll_pkg::OP_PUSH_BACK : kll_pkg::OP_POP_FRONT;
         send_request(op, pick_key(), $urandom, pick_key());
      end
   endtask

   initial begin
      // reset held high from the start, released on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_fill_to_capacity();
      test_full_pool();
      test_keyed_access();

      test_random_traffic(125, 0, 0);
      test_random_traffic(125, 80, 0);
      test_random_traffic(125, 0, 80);
      test_random_traffic(125, 36, 36);
      test_backpressure();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d results compared, list depth up to %0d of %0d",
               requests_sent, results_checked, peak_nodes, CAPACITY);
      $display("outcomes: %0d success, %0d out of memory, %0d empty, %0d key not found",
               status_tally[kll_pkg::ST_OK], status_tally[kll_pkg::ST_NOMEM],
               status_tally[kll_pkg::ST_EMPTY], status_tally[kll_pkg::ST_NOKEY]);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/kll_pkg.sv
design/kll_ram.sv
design/kll_ctrl.sv
design/keyed_linked_list_engine.sv
design/kll_checker.sv
tb/tb_top.sv
